// ----- src/ftss_pkg.sv -----
// ----------------------------------------------------------------------------
// ftss_pkg
// Shared field types and fixed constants of the fanout tree span split unit.
// ----------------------------------------------------------------------------
package ftss_pkg;

  // field widths fixed by the transaction formats
  localparam int unsigned NODE_W  = 16;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned CFG_W   = 7;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [INDEX_W-1:0] child_idx_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  // child width after reset
  localparam cfg_t CHILD_WIDTH_RESET = 7'd50;

endpackage

// ----- src/ftss_in_if.sv -----
// ----------------------------------------------------------------------------
// ftss_in_if
// Input channel: one node count per transaction.
// ----------------------------------------------------------------------------
interface ftss_in_if import ftss_pkg::*; ();
  logic  valid;
  logic  ready;
  node_t node_total;

  modport source (output valid, output node_total, input ready);
  modport sink   (input valid, input node_total, output ready);
endinterface

// ----- src/ftss_out_if.sv -----
// ----------------------------------------------------------------------------
// ftss_out_if
// Result channel: one span value per child, last child marked.
// ----------------------------------------------------------------------------
interface ftss_out_if import ftss_pkg::*; ();
  logic       valid;
  logic       ready;
  child_idx_t child_index;
  node_t      span_count;
  logic       last;

  modport source (output valid, output child_index, output span_count, output last,
                  input ready);
  modport sink   (input valid, input child_index, input span_count, input last,
                  output ready);
endinterface

// ----- src/ftss_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ftss_cfg_if
// Configuration write channel carrying the child width register.
// ----------------------------------------------------------------------------
interface ftss_cfg_if import ftss_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t child_width;

  modport source (output valid, output child_width, input ready);
  modport sink   (input valid, input child_width, output ready);
endinterface

// ----- src/ftss_ram.sv -----
// ----------------------------------------------------------------------------
// ftss_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ftss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/fanout_tree_span_split_unit.sv -----
// ----------------------------------------------------------------------------
// fanout_tree_span_split_unit
// Splits a node count over the configured children of one tree node and
// returns one span value per child, with the final child marked.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------
//  in_ch    | in  | in_ch.valid/ready      | node_total
//  out_ch   | out | out_ch.valid/ready     | child_index, span_count, last
//  cfg_ch   | in  | cfg_ch.valid/ready     | child_width
//
//  one transaction at a time: each fill visit to a child reads the span RAM,
//  then modifies and writes the entry back; output reads the RAM for each
//  child, then presents the result.
//  a count that fits in the children skips the fill entirely.
//  per-child touched flags all clear together when a transaction is taken;
//  untouched entries read as zero. reset is synchronous, active low.
//  a stalled output holds its payload; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module fanout_tree_span_split_unit import ftss_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ftss_in_if.sink    in_ch,
  ftss_out_if.source out_ch,
  ftss_cfg_if.sink   cfg_ch
);

  localparam int unsigned IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
  localparam logic [7:0]  MAX_W8 = 8'(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_OUT_RD,
    S_OUT_SHOW
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [W_W-1:0]   wcnt_t;

  state_t               state_r;
  cfg_t                 child_width_r;
  wcnt_t                width_r;
  node_t                left_r;
  idx_t                 cur_r;
  logic [MAX_WIDTH-1:0] touched_r;

  node_t rdata;
  node_t span_cur;
  node_t span_nxt;
  node_t left_nxt;
  node_t node_dec;
  node_t width16;
  node_t room16;
  wcnt_t eff_width;
  wcnt_t cur_ext;
  logic  cur_is_last;
  logic  [7:0] cw8;
  logic  [7:0] eff8;

  // effective width: zero counts as one, clamp to the storage depth
  always_comb begin
    cw8 = {1'b0, child_width_r};
    if (cw8 == 8'd0) begin
      eff8 = 8'd1;
    end else if (cw8 > MAX_W8) begin
      eff8 = MAX_W8;
    end else begin
      eff8 = cw8;
    end
    eff_width = W_W'(eff8);
  end

  assign cur_ext     = W_W'(cur_r);
  assign cur_is_last = ((cur_ext + wcnt_t'(1)) == width_r);

  // span RAM, one entry per child
  ftss_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_WIDTH)
  ) u_span_ram (
    .clk   (clk),
    .we    (state_r == S_FILL_WR),
    .waddr (cur_r),
    .wdata (span_nxt),
    .raddr (cur_r),
    .rdata (rdata)
  );

  // untouched entries read as zero
  assign span_cur = touched_r[cur_r] ? rdata : '0;

  // one fill step for the current child
  always_comb begin
    width16  = NODE_W'(width_r);
    room16   = NODE_W'(width_r - cur_ext);
    node_dec = (span_cur == '0) ? (left_r - node_t'(1)) : left_r;
    if (room16 >= left_r) begin
      // tail fits from here on: add only to a child that already has work
      span_nxt = (span_cur != '0) ? (span_cur + left_r) : span_cur;
      left_nxt = '0;
    end else if (left_r <= width16) begin
      span_nxt = span_cur + node_dec;
      left_nxt = '0;
    end else begin
      span_nxt = span_cur + width16;
      left_nxt = node_dec - width16;
    end
  end

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      child_width_r <= CHILD_WIDTH_RESET;
      width_r       <= wcnt_t'(1);
      left_r        <= '0;
      cur_r         <= '0;
      touched_r     <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        child_width_r <= cfg_ch.child_width;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            width_r   <= eff_width;
            cur_r     <= '0;
            touched_r <= '0;
            if (in_ch.node_total <= NODE_W'(eff_width)) begin
              left_r  <= '0;
              state_r <= S_OUT_RD;
            end else begin
              left_r  <= in_ch.node_total;
              state_r <= S_FILL_RD;
            end
          end
        end
        S_FILL_RD: begin
          state_r <= S_FILL_WR;
        end
        S_FILL_WR: begin
          touched_r[cur_r] <= 1'b1;
          left_r           <= left_nxt;
          if (left_nxt == '0) begin
            cur_r   <= '0;
            state_r <= S_OUT_RD;
          end else begin
            cur_r   <= cur_is_last ? '0 : (cur_r + idx_t'(1));
            state_r <= S_FILL_RD;
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_SHOW;
        end
        S_OUT_SHOW: begin
          if (out_ch.ready) begin
            if (cur_is_last) begin
              state_r <= S_IDLE;
            end else begin
              cur_r   <= cur_r + idx_t'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = (state_r == S_OUT_SHOW);
  assign out_ch.child_index = INDEX_W'(cur_r);
  assign out_ch.span_count  = span_cur;
  assign out_ch.last        = cur_is_last;

  // results only for children inside the configured width
  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (cur_ext < width_r))
    else $error("result for a child beyond the width");

  // a fill read never starts with nothing left to hand out
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL_RD) |-> (left_r != '0))
    else $error("fill step with zero remaining");

  // the last result frees the block for the next transaction
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("block not ready after final result");

  // an accepted transaction occupies the block
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction taken while busy");

endmodule
